// ===== rtl/core/ckmh_pkg.sv =====
package ckmh_pkg;

    // input item: one sequence character
    typedef struct packed {
        logic [7:0] base_char;
        logic       end_of_sequence;
    } ckmh_in_t;

    // result item: one signature word
    typedef struct packed {
        logic [3:0]  hash_index;
        logic [63:0] min_hash;
        logic        last_hash;
    } ckmh_out_t;

    // configuration port
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_HASHES  = 2'd1;

    localparam logic [5:0] KMER_LENGTH_RESET = 6'd20;
    localparam logic [4:0] NUM_HASHES_RESET  = 5'd16;

    // character codes
    localparam logic [7:0] CHAR_A = 8'h41;
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_G = 8'h47;
    localparam logic [7:0] CHAR_T = 8'h54;

    // 64-bit finaliser constants
    localparam logic [63:0] FMIX_C1    = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_C2    = 64'hc4ceb9fe1a85ec53;
    localparam int unsigned FMIX_SHIFT = 33;

endpackage

// ===== rtl/core/canonical_kmer_minhash.sv =====
// channel   | ports                                  | direction | carries
// ----------+----------------------------------------+-----------+------------------------------
// input     | s_valid, s_ready, s_data               | in        | one character per item
// result    | m_valid, m_ready, m_data               | out       | one signature word per item
// config    | cfg_valid, cfg_ready, cfg_index, cfg_data | in     | register writes, always ready
//
// a character that completes a k-mer issues num_hashes hash indices (1..16): one hash index enters
// the five-stage fmix64 pipeline per cycle, the last issue also takes the next item unless the sequence has ended
// a character before the k-mer is complete only shifts into the k-mer registers
// the end-of-sequence item waits for the pipeline to drain, then each signature word goes through
// a memory read, a load and a hand-over, and the hand-over waits while m_ready is low
// reset (aresetn low, synchronous) returns the sequence state and the registers to defaults
// the signature memory needs no clearing pass: a valid bit per entry marks written words
module canonical_kmer_minhash #(
    parameter int unsigned MAX_HASHES = 16,
    parameter int unsigned MAX_KMER   = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ckmh_pkg::ckmh_in_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ckmh_pkg::ckmh_out_t                 m_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ckmh_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [ckmh_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import ckmh_pkg::*;

    // signature words in use never exceed sixteen
    localparam int unsigned SIG_DEPTH = (MAX_HASHES < 16) ? MAX_HASHES : 16;
    localparam int unsigned AW        = (SIG_DEPTH > 1) ? $clog2(SIG_DEPTH) : 1;

    // sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_ISSUE    = 3'd1;
    localparam logic [2:0] S_DRAIN    = 3'd2;
    localparam logic [2:0] S_EMIT_RD  = 3'd3;
    localparam logic [2:0] S_EMIT_LD  = 3'd4;
    localparam logic [2:0] S_EMIT_OUT = 3'd5;

    // xor with the value shifted right by 33
    function automatic logic [63:0] xs33(input logic [63:0] x);
        return x ^ (x >> FMIX_SHIFT);
    endfunction

    // configuration registers
    logic [5:0]  kmer_length_reg;
    logic [4:0]  num_hashes_reg;

    // sequence state
    logic [2:0]  state_reg, state_next;
    logic [63:0] fwd_reg;
    logic [63:0] rev_reg;
    logic [5:0]  bases_reg;
    logic [63:0] canon_reg;
    logic        eos_reg;
    logic [4:0]  n_reg;
    logic [3:0]  m_cnt_reg;
    logic [3:0]  e_reg;
    ckmh_out_t   m_data_reg;

    // fmix64 pipeline
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic [3:0]  idx1_reg, idx2_reg, idx3_reg, idx4_reg, idx5_reg;
    logic [63:0] st1_reg;
    logic [63:0] lo2_reg;
    logic [31:0] cr2_reg;
    logic [63:0] st3_reg;
    logic [63:0] lo4_reg;
    logic [31:0] cr4_reg;
    logic [63:0] hash5_reg;

    // signature memory
    logic [63:0]          sig_mem [SIG_DEPTH];
    logic [SIG_DEPTH-1:0] sig_vld_reg;
    logic [63:0]          rd_data_reg;
    logic                 rd_vld_reg;
    logic                 fwd_hit_reg;
    logic [63:0]          fwd_data_reg;

    // combinational
    logic [1:0]  code, comp;
    logic [5:0]  k_eff;
    logic [4:0]  n_eff;
    logic [6:0]  two_k;
    logic [63:0] fwd_new, rev_new, kmask, fwd_m, rc, canon;
    logic [5:0]  bases_new;
    logic        kmer_full;
    logic        s_acc;
    logic        issue_last;
    logic        emit_last;
    logic        emit_done;
    logic        pipe_busy;
    logic [63:0] x0;
    logic [63:0] sig_q;
    logic [63:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic        fwd_hit;

    assign cfg_ready = 1'b1;

    // effective register values, zero taken as one and clamped above
    always_comb begin
        if (kmer_length_reg == 6'd0) begin
            k_eff = 6'd1;
        end else if (kmer_length_reg > 6'(MAX_KMER)) begin
            k_eff = 6'(MAX_KMER);
        end else begin
            k_eff = kmer_length_reg;
        end
        if (num_hashes_reg == 5'd0) begin
            n_eff = 5'd1;
        end else if (num_hashes_reg > 5'(SIG_DEPTH)) begin
            n_eff = 5'(SIG_DEPTH);
        end else begin
            n_eff = num_hashes_reg;
        end
    end

    // base coding, anything other than ACGT shifts zero into both registers
    always_comb begin
        case (s_data.base_char)
            CHAR_A: begin
                code = 2'd0;
                comp = 2'd3;
            end
            CHAR_C: begin
                code = 2'd1;
                comp = 2'd2;
            end
            CHAR_G: begin
                code = 2'd2;
                comp = 2'd1;
            end
            CHAR_T: begin
                code = 2'd3;
                comp = 2'd0;
            end
            default: begin
                code = 2'd0;
                comp = 2'd0;
            end
        endcase
    end

    // next k-mer registers and canonical k-mer for the item on the input
    always_comb begin
        fwd_new   = {fwd_reg[61:0], code};
        rev_new   = {comp, rev_reg[63:2]};
        bases_new = (&bases_reg) ? bases_reg : bases_reg + 6'd1;
        kmer_full = (bases_new >= k_eff);
        two_k     = {k_eff, 1'b0};
        kmask     = (k_eff == 6'd32) ? '1 : ((64'd1 << two_k) - 64'd1);
        fwd_m     = fwd_new & kmask;
        rc        = rev_new >> (7'd64 - two_k);
        canon     = (fwd_m < rc) ? fwd_m : rc;
    end

    // handshakes
    assign issue_last = ({1'b0, m_cnt_reg} == (n_reg - 5'd1));
    assign emit_last  = ({1'b0, e_reg} == (n_reg - 5'd1));
    assign s_ready    = (state_reg == S_IDLE) ||
                        ((state_reg == S_ISSUE) && issue_last && !eos_reg);
    assign s_acc      = s_valid && s_ready;
    assign m_valid    = (state_reg == S_EMIT_OUT);
    assign m_data     = m_data_reg;
    assign emit_done  = m_valid && m_ready && m_data_reg.last_hash;
    assign pipe_busy  = v1_reg || v2_reg || v3_reg || v4_reg || v5_reg;

    // sequencer
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    state_next = kmer_full ? S_ISSUE :
                                 (s_data.end_of_sequence ? S_DRAIN : S_IDLE);
                end
            end
            S_ISSUE: begin
                if (issue_last) begin
                    if (s_acc) begin
                        state_next = kmer_full ? S_ISSUE :
                                     (s_data.end_of_sequence ? S_DRAIN : S_IDLE);
                    end else begin
                        state_next = eos_reg ? S_DRAIN : S_IDLE;
                    end
                end
            end
            S_DRAIN: begin
                if (!pipe_busy) begin
                    state_next = S_EMIT_RD;
                end
            end
            S_EMIT_RD: begin
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                state_next = S_EMIT_OUT;
            end
            S_EMIT_OUT: begin
                if (m_ready) begin
                    state_next = emit_last ? S_IDLE : S_EMIT_RD;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and sequence state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            kmer_length_reg <= KMER_LENGTH_RESET;
            num_hashes_reg  <= NUM_HASHES_RESET;
            fwd_reg         <= '0;
            rev_reg         <= '1;
            bases_reg       <= '0;
            eos_reg         <= 1'b0;
            n_reg           <= 5'd1;
            m_cnt_reg       <= '0;
            e_reg           <= '0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_KMER_LENGTH: kmer_length_reg <= cfg_data[5:0];
                    REG_NUM_HASHES:  num_hashes_reg  <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if ((state_reg == S_ISSUE) && !issue_last) begin
                m_cnt_reg <= m_cnt_reg + 4'd1;
            end
            if (s_acc) begin
                fwd_reg   <= fwd_new;
                rev_reg   <= rev_new;
                bases_reg <= bases_new;
                eos_reg   <= s_data.end_of_sequence;
                n_reg     <= n_eff;
                m_cnt_reg <= '0;
            end
            if (state_reg == S_DRAIN) begin
                e_reg <= '0;
            end
            if (m_valid && m_ready && !emit_last) begin
                e_reg <= e_reg + 4'd1;
            end
            // signature handed over: start a fresh sequence
            if (emit_done) begin
                fwd_reg   <= '0;
                rev_reg   <= '1;
                bases_reg <= '0;
                eos_reg   <= 1'b0;
            end
        end
    end

    // canonical k-mer held for the issue cycles
    always_ff @(posedge aclk) begin
        if (s_acc) begin
            canon_reg <= canon;
        end
    end

    // pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            v1_reg <= (state_reg == S_ISSUE);
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // fmix64 datapath: 64-bit products split into 32-bit partial products,
    // only the low 64 bits of each product are kept
    assign x0 = canon_reg + {60'd0, m_cnt_reg};

    always_ff @(posedge aclk) begin
        // stage 1: add index, first xor-shift
        st1_reg  <= xs33(x0);
        idx1_reg <= m_cnt_reg;
        // stage 2: partial products with the first constant
        lo2_reg  <= {32'd0, st1_reg[31:0]} * {32'd0, FMIX_C1[31:0]};
        cr2_reg  <= (st1_reg[31:0] * FMIX_C1[63:32]) + (st1_reg[63:32] * FMIX_C1[31:0]);
        idx2_reg <= idx1_reg;
        // stage 3: sum, second xor-shift
        st3_reg  <= xs33(lo2_reg + {cr2_reg, 32'd0});
        idx3_reg <= idx2_reg;
        // stage 4: partial products with the second constant
        lo4_reg  <= {32'd0, st3_reg[31:0]} * {32'd0, FMIX_C2[31:0]};
        cr4_reg  <= (st3_reg[31:0] * FMIX_C2[63:32]) + (st3_reg[63:32] * FMIX_C2[31:0]);
        idx4_reg <= idx3_reg;
        // stage 5: sum, final xor-shift, lines up with the signature read
        hash5_reg <= xs33(lo4_reg + {cr4_reg, 32'd0});
        idx5_reg  <= idx4_reg;
    end

    // signature read-modify-write; a word being written back while the same
    // index is read is forwarded
    assign rd_addr = (state_reg == S_EMIT_RD) ? e_reg[AW-1:0] : idx4_reg[AW-1:0];
    assign fwd_hit = v4_reg && v5_reg && (idx4_reg == idx5_reg);
    assign sig_q   = fwd_hit_reg ? fwd_data_reg : (rd_vld_reg ? rd_data_reg : '1);
    assign wr_data = (hash5_reg < sig_q) ? hash5_reg : sig_q;

    always_ff @(posedge aclk) begin
        if (v5_reg) begin
            sig_mem[idx5_reg[AW-1:0]] <= wr_data;
        end
        rd_data_reg  <= sig_mem[rd_addr];
        fwd_data_reg <= wr_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sig_vld_reg <= '0;
            rd_vld_reg  <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end else begin
            rd_vld_reg  <= sig_vld_reg[rd_addr];
            fwd_hit_reg <= fwd_hit;
            if (emit_done) begin
                sig_vld_reg <= '0;
            end else if (v5_reg) begin
                sig_vld_reg[idx5_reg[AW-1:0]] <= 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (state_reg == S_EMIT_LD) begin
            m_data_reg.hash_index <= e_reg;
            m_data_reg.min_hash   <= sig_q;
            m_data_reg.last_hash  <= emit_last;
        end
    end

endmodule

// ===== rtl/core/ckmh_checker.sv =====
module ckmh_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_valid,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input ckmh_pkg::ckmh_out_t  m_data
);
    import ckmh_pkg::*;

    // an offered item stays on offer until taken
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid)
        else $error("input item withdrawn before it was taken");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // no item is taken while a signature word is on offer
    a_no_in_during_out: assert property (@(posedge aclk) disable iff (!aresetn)
        !(m_valid && s_ready))
        else $error("item taken during signature read-out");

    // each word is followed by a gap while the next is read
    a_out_gap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |=> !m_valid)
        else $error("back-to-back result words");

    // words of one signature come in index order
    a_index_order: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_data.last_hash |-> ##3
        (m_valid && (m_data.hash_index == 4'($past(m_data.hash_index, 3) + 4'd1))))
        else $error("signature word out of order");

endmodule

bind canonical_kmer_minhash ckmh_checker u_ckmh_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
